// ===== sv/cltu_pkg.sv =====
// Shared constants, error codes and calendar lookup functions for the civil
// local time to UTC seconds converter. No dependencies.
package cltu_pkg;

   typedef logic [2:0] err_type;

   localparam err_type ERR_OK     = 3'd0;
   localparam err_type ERR_FIELD  = 3'd1;
   localparam err_type ERR_DAY    = 3'd2;
   localparam err_type ERR_NONPOS = 3'd3;
   localparam err_type ERR_OFFSET = 3'd4;

   localparam logic [11:0] YEAR_MIN = 12'd1970;
   localparam logic [11:0] YEAR_MAX = 12'd2099;
   localparam logic [11:0] ERA5_START = 12'd2000;
   localparam logic [11:0] ERA4_START = 12'd1600;

   localparam logic signed [10:0] TZ_MIN = -11'sd720;
   localparam logic signed [10:0] TZ_MAX = 11'sd840;

   // era * 146097 - 719468 for the two eras that the year range touches
   localparam logic signed [19:0] DAYS_BASE_ERA4 = -20'sd135080;
   localparam logic signed [19:0] DAYS_BASE_ERA5 = 20'sd11017;

   localparam logic [32:0] SECS_PER_DAY = 33'd86400;

   function automatic logic [4:0] cltu_month_len(input logic [3:0] month);
      logic [4:0] len;
      unique case (month)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
         4'd2:                                        len = 5'd28;
         default:                                     len = 5'd0;
      endcase
      return len;
   endfunction

   // day of the March-based year on which each month starts
   function automatic logic [8:0] cltu_month_start(input logic [3:0] month);
      logic [8:0] start;
      unique case (month)
         4'd3:    start = 9'd0;
         4'd4:    start = 9'd31;
         4'd5:    start = 9'd61;
         4'd6:    start = 9'd92;
         4'd7:    start = 9'd122;
         4'd8:    start = 9'd153;
         4'd9:    start = 9'd184;
         4'd10:   start = 9'd214;
         4'd11:   start = 9'd245;
         4'd12:   start = 9'd275;
         4'd1:    start = 9'd306;
         4'd2:    start = 9'd337;
         default: start = 9'd0;
      endcase
      return start;
   endfunction

endpackage

// ===== sv/civil_local_time_to_utc_seconds.sv =====
// Local calendar date and time with a minute offset to UTC seconds since 1970.
// Four-stage pipeline built on cltu_pkg.
// Depends on: cltu_pkg.
//
// One transaction enters per cycle when stage 1 is free and is registered at
// each stage in turn. The stages are: field checks and day-of-era terms, day
// count and time of day, the day to seconds multiply, and the final sum with
// positivity and offset checks into the output register. Each stage carries its
// own valid bit, so a stalled result only blocks stages behind a full one and
// bubbles collapse. Errors return code 1..4 with zero seconds.
module civil_local_time_to_utc_seconds
   import cltu_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [11:0]         req_year,
   input  logic [3:0]          req_month,
   input  logic [4:0]          req_day,
   input  logic [4:0]          req_hour,
   input  logic [5:0]          req_minute,
   input  logic [5:0]          req_second,
   input  logic signed [10:0]  req_tz_offset_minutes,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [31:0]         rsp_utc_seconds,
   output logic [2:0]          rsp_error_code
);

   logic s1_valid_ff, s1_valid_in;
   logic s2_valid_ff, s2_valid_in;
   logic s3_valid_ff, s3_valid_in;
   logic out_valid_ff, out_valid_in;

   logic s1_free, s2_free, s3_free, out_free;

   // stage 1
   err_type     s1_code_ff, s1_code_in;
   logic        s1_tz_bad_ff, s1_tz_bad_in;
   logic        s1_era5_ff, s1_era5_in;
   logic [8:0]  s1_yoe_ff, s1_yoe_in;
   logic [8:0]  s1_doy_ff, s1_doy_in;
   logic [4:0]  s1_hour_ff;
   logic [5:0]  s1_minute_ff, s1_second_ff;
   logic signed [10:0] s1_tz_ff;

   // stage 2
   err_type     s2_code_ff;
   logic        s2_tz_bad_ff;
   logic [15:0] s2_days_ff, s2_days_in;
   logic [16:0] s2_tod_ff, s2_tod_in;
   logic signed [16:0] s2_tzsec_ff, s2_tzsec_in;

   // stage 3
   err_type     s3_code_ff;
   logic        s3_tz_bad_ff;
   logic [32:0] s3_daysec_ff, s3_daysec_in;
   logic signed [18:0] s3_rem_ff, s3_rem_in;

   // output
   err_type     out_code_ff, out_code_in;
   logic [31:0] out_secs_ff, out_secs_in;

   logic        range_bad, leap, day_bad, jan_feb;
   logic [4:0]  mlen;
   logic [11:0] yy, yoe_full;
   logic [1:0]  cent;
   logic [17:0] yoe_days;
   logic [19:0] days_sum;
   logic signed [34:0] utc;
   logic        nonpos;
   err_type     final_code;

   assign out_free = !out_valid_ff || rsp_ready;
   assign s3_free  = !s3_valid_ff || out_free;
   assign s2_free  = !s2_valid_ff || s3_free;
   assign s1_free  = !s1_valid_ff || s2_free;
   assign req_ready = s1_free;

   assign s1_valid_in  = s1_free  ? req_valid   : s1_valid_ff;
   assign s2_valid_in  = s2_free  ? s1_valid_ff : s2_valid_ff;
   assign s3_valid_in  = s3_free  ? s2_valid_ff : s3_valid_ff;
   assign out_valid_in = out_free ? s3_valid_ff : out_valid_ff;

   // stage 1: field checks, month length, era terms
   always_comb begin
      range_bad = (req_year < YEAR_MIN) || (req_year > YEAR_MAX) ||
                  (req_month == 4'd0) || (req_month > 4'd12) ||
                  (req_day == 5'd0) || (req_hour > 5'd23) ||
                  (req_minute > 6'd59) || (req_second > 6'd59);
      leap      = (req_year[1:0] == 2'd0);
      mlen      = cltu_month_len(req_month) +
                  {4'd0, (req_month == 4'd2) && leap};
      day_bad   = req_day > mlen;
      if (range_bad) begin
         s1_code_in = ERR_FIELD;
      end else if (day_bad) begin
         s1_code_in = ERR_DAY;
      end else begin
         s1_code_in = ERR_OK;
      end
      jan_feb      = req_month <= 4'd2;
      yy           = req_year - {11'd0, jan_feb};
      s1_era5_in   = yy >= ERA5_START;
      yoe_full     = s1_era5_in ? (yy - ERA5_START) : (yy - ERA4_START);
      s1_yoe_in    = yoe_full[8:0];
      s1_doy_in    = cltu_month_start(req_month) + {4'd0, req_day} - 9'd1;
      s1_tz_bad_in = (req_tz_offset_minutes < TZ_MIN) ||
                     (req_tz_offset_minutes > TZ_MAX);
   end

   // stage 2: day count, time of day, offset in seconds
   always_comb begin
      if (s1_yoe_ff >= 9'd300) begin
         cent = 2'd3;
      end else if (s1_yoe_ff >= 9'd200) begin
         cent = 2'd2;
      end else if (s1_yoe_ff >= 9'd100) begin
         cent = 2'd1;
      end else begin
         cent = 2'd0;
      end
      yoe_days = {9'd0, s1_yoe_ff} * 18'd365;
      days_sum = (s1_era5_ff ? DAYS_BASE_ERA5 : DAYS_BASE_ERA4) +
                 {2'd0, yoe_days} + {13'd0, s1_yoe_ff[8:2]} -
                 {18'd0, cent} + {11'd0, s1_doy_ff};
      s2_days_in  = days_sum[15:0];
      s2_tod_in   = {12'd0, s1_hour_ff} * 17'd3600 +
                    {11'd0, s1_minute_ff} * 17'd60 + {11'd0, s1_second_ff};
      s2_tzsec_in = $signed({{6{s1_tz_ff[10]}}, s1_tz_ff}) * 17'sd60;
   end

   // stage 3: days to seconds, fold in time of day and offset
   always_comb begin
      s3_daysec_in = {17'd0, s2_days_ff} * SECS_PER_DAY;
      s3_rem_in    = $signed({2'd0, s2_tod_ff}) -
                     $signed({{2{s2_tzsec_ff[16]}}, s2_tzsec_ff});
   end

   // stage 4: final sum and late checks
   always_comb begin
      utc    = $signed({2'd0, s3_daysec_ff}) + $signed({{16{s3_rem_ff[18]}}, s3_rem_ff});
      nonpos = utc[34] || (utc == 35'sd0);
      if (s3_code_ff != ERR_OK) begin
         final_code = s3_code_ff;
      end else if (nonpos) begin
         final_code = ERR_NONPOS;
      end else if (s3_tz_bad_ff) begin
         final_code = ERR_OFFSET;
      end else begin
         final_code = ERR_OK;
      end
      out_code_in = final_code;
      out_secs_in = (final_code == ERR_OK) ? utc[31:0] : 32'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_free) begin
         s1_code_ff   <= s1_code_in;
         s1_tz_bad_ff <= s1_tz_bad_in;
         s1_era5_ff   <= s1_era5_in;
         s1_yoe_ff    <= s1_yoe_in;
         s1_doy_ff    <= s1_doy_in;
         s1_hour_ff   <= req_hour;
         s1_minute_ff <= req_minute;
         s1_second_ff <= req_second;
         s1_tz_ff     <= req_tz_offset_minutes;
      end
      if (s2_free) begin
         s2_code_ff   <= s1_code_ff;
         s2_tz_bad_ff <= s1_tz_bad_ff;
         s2_days_ff   <= s2_days_in;
         s2_tod_ff    <= s2_tod_in;
         s2_tzsec_ff  <= s2_tzsec_in;
      end
      if (s3_free) begin
         s3_code_ff   <= s2_code_ff;
         s3_tz_bad_ff <= s2_tz_bad_ff;
         s3_daysec_ff <= s3_daysec_in;
         s3_rem_ff    <= s3_rem_in;
      end
      if (out_free) begin
         out_code_ff <= out_code_in;
         out_secs_ff <= out_secs_in;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_utc_seconds = out_secs_ff;
   assign rsp_error_code  = out_code_ff;

`ifndef SYNTHESIS
   a_err_zero_secs: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_error_code != ERR_OK) |-> rsp_utc_seconds == 32'd0)
      else $error("error result with nonzero seconds");

   a_ok_positive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_error_code == ERR_OK) |-> rsp_utc_seconds != 32'd0)
      else $error("ok result with zero seconds");

   a_code_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_error_code <= ERR_OFFSET)
      else $error("error code out of range");

   a_s3_hold: assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff && rsp_valid && !rsp_ready |=> s3_valid_ff && rsp_valid)
      else $error("stage 3 lost a transaction during stall");
`endif

endmodule
